@@ rtl/gppt_pkg.sv @@
// Shared constants, codes and the command record for the guest page permission table.
package gppt_pkg;

	localparam int DEF_PAGE_SHIFT = 12;
	localparam int DEF_MAX_PAGES  = 256;

	localparam int IN_W  = 144;
	localparam int OUT_W = 264;

	localparam logic [2:0] ACT_MAP     = 3'd0;
	localparam logic [2:0] ACT_UNMAP   = 3'd1;
	localparam logic [2:0] ACT_PROTECT = 3'd2;
	localparam logic [2:0] ACT_READ    = 3'd3;
	localparam logic [2:0] ACT_WRITE   = 3'd4;
	localparam logic [2:0] ACT_POP     = 3'd5;
	localparam logic [2:0] ACT_FETCH   = 3'd6;
	localparam logic [2:0] ACT_FIND    = 3'd7;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_INVALID    = 3'd1;
	localparam logic [2:0] ST_OVERLAP    = 3'd2;
	localparam logic [2:0] ST_UNMAPPED   = 3'd3;
	localparam logic [2:0] ST_PROTECTION = 3'd4;
	localparam logic [2:0] ST_NOMEM      = 3'd5;

	localparam logic [2:0] P_NONE  = 3'd0;
	localparam logic [2:0] P_READ  = 3'd1;
	localparam logic [2:0] P_WRITE = 3'd2;
	localparam logic [2:0] P_EXEC  = 3'd4;

	localparam logic [63:0] FETCH_LEN = 64'd4;

	typedef struct packed {
		logic [2:0]  action;
		logic [63:0] addr;
		logic [63:0] len;
		logic [63:0] end_m1;
		logic [2:0]  prot;
		logic [2:0]  max_prot;
		logic        jit;
		logic        replace;
		logic        thr;
		logic        locked;
		logic        rng_ok;
		logic        wrap;
		logic        misal;
	} cmd_t;

	function automatic logic [2:0] access_perm(input logic [2:0] act);
		logic [2:0] p;
		unique case (act)
			ACT_READ:  p = P_READ;
			ACT_WRITE: p = P_WRITE;
			ACT_FETCH: p = P_EXEC;
			default:   p = P_NONE;
		endcase
		return p;
	endfunction

endpackage

@@ rtl/gppt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module gppt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

@@ rtl/gppt_front.sv @@
// Front end: accepts request beats, classifies them and queues commands.
module gppt_front #(
	parameter int PAGE_SHIFT = gppt_pkg::DEF_PAGE_SHIFT
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [gppt_pkg::IN_W-1:0] s_tdata,
	input  logic [2:0]              s_tuser,
	output logic                    cmd_valid,
	input  logic                    cmd_pop,
	output gppt_pkg::cmd_t          cmd
);
	import gppt_pkg::*;

	cmd_t       ent_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	cmd_t       cls;
	logic [63:0] a, n;
	logic       push;

	always_comb begin
		a = s_tdata[63:0];
		n = (s_tuser == ACT_FETCH) ? FETCH_LEN : s_tdata[127:64];
		cls.action   = s_tuser;
		cls.addr     = a;
		cls.len      = n;
		cls.end_m1   = a + n - 64'd1;
		cls.prot     = s_tdata[130:128];
		cls.max_prot = s_tdata[133:131];
		cls.jit      = s_tdata[134];
		cls.replace  = s_tdata[135];
		cls.thr      = s_tdata[136] && (s_tuser == ACT_WRITE || s_tuser == ACT_FETCH);
		cls.locked   = s_tdata[137];
		cls.wrap     = n > ~a;
		cls.rng_ok   = (n != 64'd0) && (a[PAGE_SHIFT-1:0] == '0) &&
			(n[PAGE_SHIFT-1:0] == '0) && !cls.wrap;
		cls.misal    = (s_tuser == ACT_FETCH) && (a[1:0] != 2'd0);
	end

	assign s_tready  = (cnt_q != 2'd2);
	assign push      = s_tvalid && s_tready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (cmd_pop) rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, cmd_pop};
		end
	end
endmodule

@@ rtl/gppt_back.sv @@
// Back end: walks the page table in RAM, merges updates into the spare bank, drives results.
module gppt_back #(
	parameter int PAGE_SHIFT = gppt_pkg::DEF_PAGE_SHIFT,
	parameter int MAX_PAGES  = gppt_pkg::DEF_MAX_PAGES
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cmd_valid,
	output logic                      cmd_pop,
	input  gppt_pkg::cmd_t            cmd,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [gppt_pkg::OUT_W-1:0] m_tdata
);
	import gppt_pkg::*;

	localparam int PNW = 64 - PAGE_SHIFT;
	localparam int CW  = $clog2(MAX_PAGES + 1);
	localparam int AW  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam int EW  = PNW + 7;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_SETUP  = 4'd1;
	localparam logic [3:0] S_RD1    = 4'd2;
	localparam logic [3:0] S_EV1    = 4'd3;
	localparam logic [3:0] S_DECIDE = 4'd4;
	localparam logic [3:0] S_RD2    = 4'd5;
	localparam logic [3:0] S_EV2    = 4'd6;
	localparam logic [3:0] S_INS    = 4'd7;
	localparam logic [3:0] S_DONE   = 4'd8;

	logic [3:0]     state_q;
	cmd_t           cmd_q;
	logic [CW-1:0]  count_q, i_q, w_q, cnt_in_q, j_q;
	logic [PNW-1:0] cur_q, cand_q, ep_q;
	logic           first_q, exec_q, bad_q, ins_q, bank_q;
	logic [63:0]    gen_q, code_q, fault_q, found_q;
	logic [2:0]     status_q;
	logic           m_tvalid_q;
	logic [OUT_W-1:0] m_tdata_q;

	logic [EW-1:0]  rd0, rd1, rd, wdata;
	logic           wen;
	logic [PNW-1:0] e_pn, sp, lp, np, nc;
	logic [2:0]     e_prot, e_maxp, perm;
	logic           e_jit, is_acc, is_wr, jit_deny, in_rng, nomem;
	logic [PNW:0]   cand_sum, nc_sum;
	logic [CW-1:0]  keep, room;
	logic [63:0]    fault_here;

	gppt_ram #(.WIDTH(EW), .DEPTH(MAX_PAGES), .AW(AW)) u_bank0 (
		.clk(clk), .we(wen && bank_q), .waddr(w_q[AW-1:0]), .wdata(wdata),
		.raddr(i_q[AW-1:0]), .rdata(rd0)
	);
	gppt_ram #(.WIDTH(EW), .DEPTH(MAX_PAGES), .AW(AW)) u_bank1 (
		.clk(clk), .we(wen && !bank_q), .waddr(w_q[AW-1:0]), .wdata(wdata),
		.raddr(i_q[AW-1:0]), .rdata(rd1)
	);

	always_comb begin
		rd       = bank_q ? rd1 : rd0;
		e_pn     = rd[PNW-1:0];
		e_prot   = rd[PNW+2:PNW];
		e_maxp   = rd[PNW+5:PNW+3];
		e_jit    = rd[PNW+6];
		sp       = cmd_q.addr[63:PAGE_SHIFT];
		lp       = cmd_q.end_m1[63:PAGE_SHIFT];
		np       = cmd_q.len[63:PAGE_SHIFT];
		nc       = e_pn + 1'b1;
		cand_sum = {1'b0, cand_q} + {1'b0, np};
		nc_sum   = {1'b0, nc} + {1'b0, np};
		perm     = access_perm(cmd_q.action);
		is_acc   = (cmd_q.action == ACT_READ) || (cmd_q.action == ACT_WRITE) ||
			(cmd_q.action == ACT_POP) || (cmd_q.action == ACT_FETCH);
		is_wr    = (cmd_q.action == ACT_WRITE) || (cmd_q.action == ACT_POP);
		jit_deny = e_jit && cmd_q.thr && ((perm == P_WRITE && cmd_q.locked) ||
			(perm == P_EXEC && !cmd_q.locked));
		in_rng   = (e_pn >= sp) && (e_pn < ep_q);
		keep     = count_q - cnt_in_q;
		room     = CW'(MAX_PAGES) - keep;
		nomem    = np > PNW'(room);
		fault_here = first_q ? cmd_q.addr : {cur_q, {PAGE_SHIFT{1'b0}}};
		wen      = 1'b0;
		wdata    = rd;
		if (state_q == S_INS) begin
			wen   = 1'b1;
			wdata = {cmd_q.jit, cmd_q.max_prot, cmd_q.prot, sp + PNW'(j_q)};
		end else if (state_q == S_EV2) begin
			if (!(cmd_q.action == ACT_MAP && !ins_q && e_pn >= sp)) begin
				if (!in_rng) begin
					wen = 1'b1;
				end else if (cmd_q.action == ACT_PROTECT) begin
					wen   = 1'b1;
					wdata = {e_jit, e_maxp, cmd_q.prot, e_pn};
				end
			end
		end
	end

	assign cmd_pop  = (state_q == S_IDLE) && cmd_valid;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_ff @(posedge clk) begin
		if (cmd_pop) cmd_q <= cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			i_q        <= '0;
			w_q        <= '0;
			j_q        <= '0;
			cnt_in_q   <= '0;
			cur_q      <= '0;
			cand_q     <= '0;
			ep_q       <= '0;
			first_q    <= 1'b0;
			exec_q     <= 1'b0;
			bad_q      <= 1'b0;
			ins_q      <= 1'b0;
			bank_q     <= 1'b0;
			gen_q      <= '0;
			code_q     <= '0;
			fault_q    <= '0;
			found_q    <= '0;
			status_q   <= ST_OK;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			// drop the beat once taken, unless a new one replaces it
			if (m_tvalid_q && m_tready && state_q != S_DONE) m_tvalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) state_q <= S_SETUP;
				end
				S_SETUP: begin
					found_q  <= '0;
					i_q      <= '0;
					cnt_in_q <= '0;
					bad_q    <= 1'b0;
					exec_q   <= 1'b0;
					first_q  <= 1'b1;
					cur_q    <= sp;
					cand_q   <= sp;
					ep_q     <= lp + 1'b1;
					state_q  <= S_RD1;
					if (is_acc) begin
						if (cmd_q.misal || cmd_q.wrap) begin
							status_q <= ST_INVALID;
							fault_q  <= cmd_q.addr;
							state_q  <= S_DONE;
						end else if (cmd_q.len == 64'd0) begin
							status_q <= ST_OK;
							fault_q  <= '0;
							state_q  <= S_DONE;
						end
					end else if (!cmd_q.rng_ok || (cmd_q.action == ACT_MAP &&
						(cmd_q.prot & ~cmd_q.max_prot) != 3'd0)) begin
						status_q <= ST_INVALID;
						state_q  <= S_DONE;
					end
				end
				S_RD1: begin
					if (i_q == count_q) begin
						if (is_acc) begin
							status_q <= ST_UNMAPPED;
							fault_q  <= fault_here;
							state_q  <= S_DONE;
						end else if (cmd_q.action == ACT_FIND) begin
							status_q <= ST_OK;
							found_q  <= {cand_q, {PAGE_SHIFT{1'b0}}};
							state_q  <= S_DONE;
						end else begin
							state_q <= S_DECIDE;
						end
					end else begin
						state_q <= S_EV1;
					end
				end
				S_EV1: begin
					state_q <= S_RD1;
					if (is_acc) begin
						if (e_pn < cur_q) begin
							i_q <= i_q + 1'b1;
						end else if (e_pn != cur_q) begin
							status_q <= ST_UNMAPPED;
							fault_q  <= fault_here;
							state_q  <= S_DONE;
						end else if ((e_prot & perm) != perm || jit_deny) begin
							status_q <= ST_PROTECTION;
							fault_q  <= fault_here;
							state_q  <= S_DONE;
						end else if (cur_q == lp) begin
							status_q <= ST_OK;
							fault_q  <= '0;
							if (is_wr) begin
								gen_q <= gen_q + 64'd1;
								if (exec_q || e_prot[2]) code_q <= code_q + 64'd1;
							end
							state_q <= S_DONE;
						end else begin
							exec_q  <= exec_q || e_prot[2];
							cur_q   <= cur_q + 1'b1;
							first_q <= 1'b0;
							i_q     <= i_q + 1'b1;
						end
					end else if (cmd_q.action == ACT_FIND) begin
						if (e_pn < sp) begin
							i_q <= i_q + 1'b1;
						end else if ({1'b0, e_pn} >= cand_sum) begin
							status_q <= ST_OK;
							found_q  <= {cand_q, {PAGE_SHIFT{1'b0}}};
							state_q  <= S_DONE;
						end else if (nc_sum[PNW]) begin
							status_q <= ST_NOMEM;
							state_q  <= S_DONE;
						end else begin
							cand_q <= nc;
							i_q    <= i_q + 1'b1;
						end
					end else if (e_pn >= ep_q) begin
						state_q <= S_DECIDE;
					end else begin
						if (e_pn >= sp) begin
							cnt_in_q <= cnt_in_q + 1'b1;
							if ((cmd_q.prot & ~e_maxp) != 3'd0) bad_q <= 1'b1;
						end
						i_q <= i_q + 1'b1;
					end
				end
				S_DECIDE: begin
					i_q     <= '0;
					w_q     <= '0;
					ins_q   <= 1'b0;
					state_q <= S_RD2;
					if (cmd_q.action == ACT_MAP) begin
						if (!cmd_q.replace && cnt_in_q != '0) begin
							status_q <= ST_OVERLAP;
							state_q  <= S_DONE;
						end else if (nomem) begin
							status_q <= ST_NOMEM;
							state_q  <= S_DONE;
						end
					end else if (cmd_q.action == ACT_PROTECT) begin
						if (PNW'(cnt_in_q) != np) begin
							status_q <= ST_UNMAPPED;
							state_q  <= S_DONE;
						end else if (bad_q) begin
							status_q <= ST_PROTECTION;
							state_q  <= S_DONE;
						end
					end
				end
				S_RD2: begin
					if (i_q == count_q) begin
						if (cmd_q.action == ACT_MAP && !ins_q) begin
							j_q     <= '0;
							state_q <= S_INS;
						end else begin
							bank_q   <= !bank_q;
							count_q  <= w_q;
							gen_q    <= gen_q + 64'd1;
							code_q   <= code_q + 64'd1;
							status_q <= ST_OK;
							state_q  <= S_DONE;
						end
					end else begin
						state_q <= S_EV2;
					end
				end
				S_EV2: begin
					if (cmd_q.action == ACT_MAP && !ins_q && e_pn >= sp) begin
						j_q     <= '0;
						state_q <= S_INS;
					end else begin
						if (wen) w_q <= w_q + 1'b1;
						i_q     <= i_q + 1'b1;
						state_q <= S_RD2;
					end
				end
				S_INS: begin
					w_q <= w_q + 1'b1;
					j_q <= j_q + 1'b1;
					if (PNW'(j_q) + 1'b1 == np) begin
						ins_q   <= 1'b1;
						state_q <= S_RD2;
					end
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {5'd0, code_q, gen_q, found_q, fault_q, status_q};
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_PAGES))
		else $error("page count above capacity");
	a_write_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EV2 || state_q == S_INS) && wen |-> w_q < CW'(MAX_PAGES))
		else $error("merge writes past capacity");
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EV1 || state_q == S_EV2) |-> i_q < count_q)
		else $error("walk index beyond table");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |=> state_q == S_SETUP)
		else $error("command taken outside idle");
endmodule

@@ rtl/guest_page_permission_table.sv @@
// Top level of the guest page permission table.
//  channel | dir | tdata / tuser
//  s_      | in  | request: tuser action, tdata address, length, prot, ...
//  m_      | out | result: status, fault, found, generation, code generation
// A command scans the table entry by entry; when map, unmap or protect changes the
// table it also walks every entry in the merge, and map inserts each of its pages.
// Accesses and find free stop at the deciding entry. Each entry is read, then evaluated,
// as the RAM's read is registered. Asynchronous reset empties the table.
// The input queue holds two requests while a result waits on m_tready.
module guest_page_permission_table #(
	parameter int PAGE_SHIFT = gppt_pkg::DEF_PAGE_SHIFT,
	parameter int MAX_PAGES  = gppt_pkg::DEF_MAX_PAGES
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// address[63:0], length[127:64], prot, max_prot, jit_page, replace,
	// has_thread, thread_jit_locked, zero pad
	input  logic [gppt_pkg::IN_W-1:0] s_tdata,
	// action
	input  logic [2:0] s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// status, last fault, found, generation, code generation, zero pad
	output logic [gppt_pkg::OUT_W-1:0] m_tdata
);
	import gppt_pkg::*;

	cmd_t cmd;
	logic cmd_valid, cmd_pop;

	gppt_front #(.PAGE_SHIFT(PAGE_SHIFT)) u_front (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.s_tdata(s_tdata), .s_tuser(s_tuser), .cmd_valid(cmd_valid),
		.cmd_pop(cmd_pop), .cmd(cmd)
	);

	gppt_back #(.PAGE_SHIFT(PAGE_SHIFT), .MAX_PAGES(MAX_PAGES)) u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd_pop(cmd_pop),
		.cmd(cmd), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);
endmodule
